>>> src/four_lane_rotate_multiply_hash_defines.svh
// assertion macros for the four-lane rotate-multiply hash
// used by flrmh_mul and four_lane_rotate_multiply_hash; expects clk and arst_n in scope
`ifndef FOUR_LANE_ROTATE_MULTIPLY_HASH_DEFINES_SVH
`define FOUR_LANE_ROTATE_MULTIPLY_HASH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FLRMH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FLRMH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/flrmh_pkg.sv
// shared constants, types and helpers for the four-lane rotate-multiply hash
// no dependencies
`default_nettype none

package flrmh_pkg;

	// length field handling
	localparam int LenBits = 32;
	localparam int IdxW = LenBits - 3;

	// multiplier constants
	localparam logic [63:0] MulG  = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MulM1 = 64'h85EBCA77C2B2AE3D;
	localparam logic [63:0] MulM2 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MulM3 = 64'h94D049BB133111EB;

	// lane rotations
	localparam logic [5:0] RotLane1 = 6'd11;
	localparam logic [5:0] RotLane2 = 6'd17;
	localparam logic [5:0] RotLane3 = 6'd23;
	localparam logic [5:0] RotLane4 = 6'd57;

	// finalizer xorshifts
	localparam int ShiftF0 = 29;
	localparam int ShiftF1 = 31;
	localparam int ShiftF2 = 37;
	localparam int ShiftF3 = 41;

	// configuration register indexes
	localparam logic CfgFoldRotA = 1'b0;
	localparam logic CfgFoldRotB = 1'b1;

	// lane select codes
	localparam logic [1:0] LaneOne   = 2'd0;
	localparam logic [1:0] LaneTwo   = 2'd1;
	localparam logic [1:0] LaneThree = 2'd2;
	localparam logic [1:0] LaneFour  = 2'd3;

	// multiplier status
	typedef struct packed {
		logic busy;
		logic done;
	} flrmh_mul_stat_t;

	// left rotate, zero amount is identity
	function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] k);
		logic [6:0] rs;
		rs = 7'd64 - {1'b0, k};
		if (k == 6'd0) begin
			return v;
		end
		return (v << k) | (v >> rs);
	endfunction

endpackage

`default_nettype wire

>>> src/flrmh_mul.sv
// shared 64x64 mod 2^64 multiplier, one 32x32 partial product per cycle
// depends on flrmh_pkg and four_lane_rotate_multiply_hash_defines.svh
`default_nettype none
`include "four_lane_rotate_multiply_hash_defines.svh"

module flrmh_mul (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [63:0]               a,
	input  wire logic [63:0]               b,
	output flrmh_pkg::flrmh_mul_stat_t     stat,
	output logic [63:0]                    prod
);
	import flrmh_pkg::*;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] part;

	// operand select: low*low, low*high, high*low
	always_comb begin
		op_x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		op_y = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
		part = {32'd0, op_x} * {32'd0, op_y};
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
	end

	// accumulate partial products
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= part;
			end else begin
				acc_q <= acc_q + {part[31:0], 32'd0};
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod = acc_q;

	`FLRMH_ASSERT_NXT(a_start_busy, start, busy_q && !done_q, "multiplier did not start")
	`FLRMH_ASSERT_NXT(a_last_done, busy_q && step_q == 2'd2 && !start, done_q && !busy_q,
		"multiplier did not finish after last partial")

endmodule

`default_nettype wire

>>> src/four_lane_rotate_multiply_hash.sv
// Four-lane rotate-multiply hash, one 64-bit message word per input word.
// A plain word is accepted, then mixed. A first word adds seeding: five
// products on the shared multiplier. A last word adds the fold, three
// finalizer products, then load of the output register.
// Reset (arst_n, async) clears lanes, counters, rotations, handshakes.
// depends on flrmh_pkg, flrmh_mul and four_lane_rotate_multiply_hash_defines.svh
`default_nettype none
`include "four_lane_rotate_multiply_hash_defines.svh"

module four_lane_rotate_multiply_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        first_word,
	input  wire logic        last_word,
	input  wire logic [63:0] seed,
	input  wire logic [31:0] total_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      hash_value
);
	import flrmh_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEED = 6'b000010,
		ST_MIX  = 6'b000100,
		ST_FOLD = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t          state_q;
	logic [2:0]      seed_cnt_q;
	logic [1:0]      fin_cnt_q;
	logic [5:0]      fold_rot_a_q;
	logic [5:0]      fold_rot_b_q;
	logic [63:0]     lane_one_q;
	logic [63:0]     lane_two_q;
	logic [63:0]     lane_three_q;
	logic [63:0]     lane_four_q;
	logic [IdxW-1:0] word_index_q;
	logic [IdxW-1:0] group_limit_q;
	logic [63:0]     data_q;
	logic            mix_en_q;
	logic            last_q;
	logic [63:0]     seed_q;
	logic [63:0]     base_q;
	logic            out_valid_q;
	logic [63:0]     hash_q;

	logic            in_fire;
	logic [3:0]      cnt_sat;
	logic [63:0]     byte_mask;
	logic [63:0]     len_ext;
	logic [IdxW-1:0] group_limit;
	logic [1:0]      lane_sel;
	logic [63:0]     mix_one;
	logic [63:0]     mix_two;
	logic [63:0]     mix_three;
	logic [63:0]     mix_four;
	logic [63:0]     fold_x;
	logic            emit_load;
	logic            mul_start;
	logic [63:0]     mul_a;
	logic [63:0]     mul_b;
	logic [63:0]     mul_prod;
	flrmh_mul_stat_t mul_st;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign hash_value = hash_q;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// byte masking and length fields of the incoming word
	always_comb begin
		cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
		if (cnt_sat == 4'd8) begin
			byte_mask = '1;
		end else begin
			byte_mask = (64'd1 << {cnt_sat[2:0], 3'b000}) - 64'd1;
		end
		len_ext = 64'(total_length[LenBits-1:0]);
		group_limit = {total_length[LenBits-1:5], 2'b00};
	end

	// lane routing and add-rotate-xor mixing
	always_comb begin
		lane_sel = (word_index_q < group_limit_q) ? word_index_q[1:0] : LaneOne;
		mix_one = rotl64((lane_one_q ^ data_q) + lane_two_q, RotLane1);
		mix_two = rotl64((lane_two_q ^ data_q) + lane_three_q, RotLane2);
		mix_three = rotl64((lane_three_q ^ data_q) + lane_four_q, RotLane3);
		mix_four = rotl64((lane_four_q ^ data_q) + lane_one_q, RotLane4);
	end

	// lane fold and first xorshift
	always_comb begin
		logic [63:0] f;
		f = lane_one_q ^ rotl64(lane_two_q, fold_rot_a_q)
			^ lane_three_q ^ rotl64(lane_four_q, fold_rot_b_q);
		fold_x = f ^ (f >> ShiftF0);
	end

	// multiplier requests
	always_comb begin
		mul_start = 1'b0;
		mul_a = base_q;
		mul_b = MulG;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && first_word) begin
					mul_start = 1'b1;
					mul_a = len_ext;
				end
			end
			ST_SEED: begin
				if (mul_st.done) begin
					case (seed_cnt_q)
						3'd0: begin
							mul_start = 1'b1;
							mul_a = seed_q ^ mul_prod;
						end
						3'd1: begin
							mul_start = 1'b1;
							mul_b = MulM1;
						end
						3'd2: begin
							mul_start = 1'b1;
							mul_b = MulM2;
						end
						3'd3: begin
							mul_start = 1'b1;
							mul_b = MulM3;
						end
						default: mul_start = 1'b0;
					endcase
				end
			end
			ST_FOLD: begin
				mul_start = 1'b1;
				mul_a = fold_x;
				mul_b = MulM1;
			end
			ST_FIN: begin
				if (mul_st.done) begin
					case (fin_cnt_q)
						2'd0: begin
							mul_start = 1'b1;
							mul_a = mul_prod ^ (mul_prod >> ShiftF1);
							mul_b = MulM2;
						end
						2'd1: begin
							mul_start = 1'b1;
							mul_a = mul_prod ^ (mul_prod >> ShiftF2);
							mul_b = MulG;
						end
						default: mul_start = 1'b0;
					endcase
				end
			end
			default: mul_start = 1'b0;
		endcase
	end

	flrmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_st),
		.prod   (mul_prod)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_rot_a_q <= 6'd0;
			fold_rot_b_q <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgFoldRotA: fold_rot_a_q <= cfg_wdata;
				CfgFoldRotB: fold_rot_b_q <= cfg_wdata;
				default: fold_rot_a_q <= fold_rot_a_q;
			endcase
		end
	end

	// captured input word and seed, and the seeding base
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= data_word & byte_mask;
			seed_q <= seed;
		end
		if (state_q == ST_SEED && mul_st.done && seed_cnt_q == 3'd0) begin
			base_q <= seed_q ^ mul_prod;
		end
	end

	// sequencer, lanes and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_cnt_q <= 3'd0;
			fin_cnt_q <= 2'd0;
			mix_en_q <= 1'b0;
			last_q <= 1'b0;
			lane_one_q <= 64'd0;
			lane_two_q <= 64'd0;
			lane_three_q <= 64'd0;
			lane_four_q <= 64'd0;
			word_index_q <= '0;
			group_limit_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mix_en_q <= (byte_count != 4'd0);
						last_q <= last_word;
						seed_cnt_q <= 3'd0;
						if (first_word) begin
							word_index_q <= '0;
							group_limit_q <= group_limit;
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_MIX;
						end
					end
				end
				ST_SEED: begin
					if (mul_st.done) begin
						seed_cnt_q <= seed_cnt_q + 3'd1;
						case (seed_cnt_q)
							3'd1: lane_one_q <= mul_prod;
							3'd2: lane_two_q <= mul_prod;
							3'd3: lane_three_q <= mul_prod;
							3'd4: begin
								lane_four_q <= mul_prod;
								state_q <= ST_MIX;
							end
							default: ;
						endcase
					end
				end
				ST_MIX: begin
					if (mix_en_q) begin
						case (lane_sel)
							LaneOne:   lane_one_q <= mix_one;
							LaneTwo:   lane_two_q <= mix_two;
							LaneThree: lane_three_q <= mix_three;
							default:   lane_four_q <= mix_four;
						endcase
						word_index_q <= word_index_q + 1'b1;
					end
					state_q <= last_q ? ST_FOLD : ST_IDLE;
				end
				ST_FOLD: begin
					fin_cnt_q <= 2'd0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (mul_st.done) begin
						fin_cnt_q <= fin_cnt_q + 2'd1;
						if (fin_cnt_q == 2'd2) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			hash_q <= mul_prod ^ (mul_prod >> ShiftF3);
		end
	end

	`FLRMH_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "ready while a word is at work")
	`FLRMH_ASSERT_IMP(a_mul_free, mul_start, !mul_st.busy, "multiplier started while busy")
	`FLRMH_ASSERT_NXT(a_emit_loads, emit_load, out_valid && in_ready,
		"finished hash not presented")

endmodule

`default_nettype wire

>>> test/four_lane_rotate_multiply_hash_tb.sv
// self-checking testbench for the four-lane rotate-multiply hash
// holds its own model of the lanes, drives words with random gaps and checks every hash
// depends on flrmh_pkg and four_lane_rotate_multiply_hash
`timescale 1ns / 1ps

module four_lane_rotate_multiply_hash_tb;
	import flrmh_pkg::*;

	localparam int unsigned StallLimit = 5000;
	localparam int unsigned DrainCycles = 64;
	localparam int unsigned LongHold = 600;
	localparam int unsigned WordsPerPhase = 190;
	localparam int unsigned MaxReports = 10;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
		logic        last;
		logic [63:0] seed;
		logic [31:0] length;
	} msg_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [5:0]  cfg_wdata = 6'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] data_word = 64'd0;
	logic [3:0]  byte_count = 4'd0;
	logic        first_word = 1'b0;
	logic        last_word = 1'b0;
	logic [63:0] seed = 64'd0;
	logic [31:0] total_length = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash_value;

	four_lane_rotate_multiply_hash u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first_word   (first_word),
		.last_word    (last_word),
		.seed         (seed),
		.total_length (total_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic [63:0]     lane1 = '0, lane2 = '0, lane3 = '0, lane4 = '0;
	logic [IdxW-1:0] word_pos = '0, group_words = '0;
	logic [5:0]      fold_a_model = '0, fold_b_model = '0;

	msg_word_t   pending_words[$];
	logic [63:0] expected_hashes[$];
	int unsigned offered_words = 0;
	int unsigned accepted_words = 0;
	int unsigned hashes_checked = 0;
	int unsigned hash_errors = 0;
	int unsigned fold_settings = 1;
	bit          calm_sender = 1'b0;
	bit          calm_receiver = 1'b0;

	// left rotate, the upper half of the doubled word
	function automatic logic [63:0] rot_left(input logic [63:0] v, input logic [5:0] k);
		logic [127:0] twice;
		twice = {v, v} << k;
		return twice[127:64];
	endfunction

	// gap length: mostly none, some short, a few long; always none when calm
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 10);
	endfunction

	// advance the model by one accepted word, report a finished hash
	task automatic advance_hash(input msg_word_t w, output bit emits, output logic [63:0] h);
		logic [63:0] len64, base, d, a, c;
		int unsigned n;
		logic [1:0] sel;
		if (w.first) begin
			len64 = 64'(w.length);
			if (LenBits < 32) begin
				len64 = len64 & ((64'd1 << LenBits) - 64'd1);
			end
			base = w.seed ^ (len64 * MulG);
			lane1 = base * MulG;
			lane2 = base * MulM1;
			lane3 = base * MulM2;
			lane4 = base * MulM3;
			word_pos = '0;
			group_words = IdxW'((len64 >> 5) << 2);
		end
		n = (w.count > 4'd8) ? 8 : w.count;
		if (n != 0) begin
			d = w.data;
			if (n < 8) begin
				d = d & ((64'd1 << (8 * n)) - 64'd1);
			end
			// words inside whole groups go round-robin, the rest into lane one
			sel = (word_pos < group_words) ? word_pos[1:0] : LaneOne;
			case (sel)
				LaneOne: begin
					lane1 = rot_left((lane1 ^ d) + lane2, RotLane1);
				end
				LaneTwo: begin
					lane2 = rot_left((lane2 ^ d) + lane3, RotLane2);
				end
				LaneThree: begin
					lane3 = rot_left((lane3 ^ d) + lane4, RotLane3);
				end
				default: begin
					lane4 = rot_left((lane4 ^ d) + lane1, RotLane4);
				end
			endcase
			word_pos = word_pos + 1'b1;
		end
		emits = w.last;
		h = '0;
		if (w.last) begin
			// fold the lanes, then the finalizer
			a = lane1 ^ rot_left(lane2, fold_a_model);
			c = lane3 ^ rot_left(lane4, fold_b_model);
			a = a ^ c;
			a = a ^ (a >> ShiftF0);
			a = a * MulM1;
			a = a ^ (a >> ShiftF1);
			a = a * MulM2;
			a = a ^ (a >> ShiftF2);
			a = a * MulG;
			a = a ^ (a >> ShiftF3);
			h = a;
		end
	endtask

	// sender: present queued words with random gaps
	msg_word_t   staged_word;
	int unsigned send_gap = 0;

	always @(negedge clk) begin
		if (accepted_words == offered_words) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_words.size() != 0) begin
				staged_word = pending_words.pop_front();
				data_word <= staged_word.data;
				byte_count <= staged_word.count;
				first_word <= staged_word.first;
				last_word <= staged_word.last;
				seed <= staged_word.seed;
				total_length <= staged_word.length;
				in_valid <= 1'b1;
				offered_words++;
				send_gap = pick_gap(calm_sender);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus two long hold-offs to back the block up
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	int unsigned long_holds = 0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (long_holds < 2 && hashes_checked >= 20 + 40 * long_holds) begin
			out_ready <= 1'b0;
			hold_left = LongHold - 1;
			long_holds++;
		end else if (recv_gap != 0) begin
			out_ready <= 1'b0;
			recv_gap--;
		end else begin
			out_ready <= 1'b1;
			recv_gap = pick_gap(calm_receiver);
		end
	end

	// input monitor: feed every accepted word to the model
	msg_word_t   seen_word;
	bit          seen_emits;
	logic [63:0] seen_hash;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			seen_word.data = data_word;
			seen_word.count = byte_count;
			seen_word.first = first_word;
			seen_word.last = last_word;
			seen_word.seed = seed;
			seen_word.length = total_length;
			advance_hash(seen_word, seen_emits, seen_hash);
			if (seen_emits) begin
				expected_hashes.push_back(seen_hash);
			end
			accepted_words++;
		end
	end

	// output monitor: compare each hash with the oldest expectation
	logic [63:0] want_hash;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hashes.size() == 0) begin
				hash_errors++;
				if (hash_errors <= MaxReports) begin
					$display("unexpected hash %016h", hash_value);
				end
			end else begin
				want_hash = expected_hashes.pop_front();
				if (hash_value !== want_hash) begin
					hash_errors++;
					if (hash_errors <= MaxReports) begin
						$display("hash mismatch: expected %016h got %016h",
							want_hash, hash_value);
					end
				end
			end
			hashes_checked++;
		end
	end

	// watchdog on cycles with no word moving on either side
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= StallLimit) begin
			$display("watchdog: no progress for %0d cycles", StallLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_word(input logic [63:0] data, input logic [3:0] count,
			input logic first, input logic last, input logic [63:0] sd,
			input logic [31:0] length);
		msg_word_t w;
		w.data = data;
		w.count = count;
		w.first = first;
		w.last = last;
		w.seed = sd;
		w.length = length;
		pending_words.push_back(w);
	endtask

	// one message of nbytes bytes; declared length and marks can be broken on purpose
	task automatic queue_message(input logic [63:0] sd, input int unsigned nbytes,
			input logic [31:0] declared, input bit with_first, input bit with_last);
		int unsigned nwords;
		int unsigned rem;
		logic [3:0] cnt;
		nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
		for (int unsigned i = 0; i < nwords; i++) begin
			rem = nbytes - 8 * i;
			cnt = (rem >= 8) ? 4'd8 : 4'(rem);
			queue_word({$urandom, $urandom}, cnt, with_first && (i == 0),
				with_last && (i == nwords - 1),
				(i == 0) ? sd : {$urandom, $urandom},
				(i == 0) ? declared : 32'($urandom));
		end
	endtask

	// random traffic: mostly well-formed messages, some noise and broken ones
	task automatic queue_random(input int unsigned target);
		int unsigned start;
		int unsigned r;
		int unsigned nbytes;
		start = pending_words.size();
		while (pending_words.size() - start < target) begin
			r = $urandom_range(99, 0);
			if (r < 85) begin
				r = $urandom_range(99, 0);
				if (r < 85) begin
					nbytes = $urandom_range(64, 0);
				end else if (r < 97) begin
					nbytes = $urandom_range(160, 65);
				end else begin
					nbytes = $urandom_range(400, 161);
				end
				queue_message({$urandom, $urandom}, nbytes, nbytes, 1'b1, 1'b1);
			end else if (r < 92) begin
				repeat ($urandom_range(3, 1)) begin
					queue_word({$urandom, $urandom}, 4'($urandom_range(15, 0)),
						1'($urandom), 1'($urandom), {$urandom, $urandom},
						32'($urandom));
				end
			end else begin
				nbytes = $urandom_range(96, 1);
				case ($urandom_range(2, 0))
					0: queue_message({$urandom, $urandom}, nbytes,
						32'($urandom_range(200, 0)), 1'b1, 1'b1);
					1: queue_message({$urandom, $urandom}, nbytes, nbytes, 1'b0, 1'b1);
					default: queue_message({$urandom, $urandom}, nbytes, nbytes,
						1'b1, 1'b0);
				endcase
			end
		end
	endtask

	// wait until every word is in and every hash out, then let the block settle
	task automatic wait_drained();
		while (pending_words.size() != 0 || accepted_words != offered_words
				|| expected_hashes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_fold(input logic [5:0] rot_a, input logic [5:0] rot_b);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CfgFoldRotA;
		cfg_wdata <= rot_a;
		@(negedge clk);
		cfg_index <= CfgFoldRotB;
		cfg_wdata <= rot_b;
		@(negedge clk);
		cfg_we <= 1'b0;
		fold_a_model = rot_a;
		fold_b_model = rot_b;
		fold_settings++;
	endtask

	// stimulus sequence
	initial begin
		logic [5:0] rot_a_list[4];
		logic [5:0] rot_b_list[4];
		rot_a_list = '{6'd63, 6'd1, 6'($urandom_range(63, 0)), 6'd0};
		rot_b_list = '{6'd63, 6'd62, 6'($urandom_range(63, 0)), 6'd31};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: words before any seeding, from zero lanes
		queue_word('1, 4'd8, 1'b0, 1'b0, '0, '0);
		queue_word('1, 4'd5, 1'b0, 1'b1, '0, '0);
		// empty message
		queue_word({$urandom, $urandom}, 4'd0, 1'b1, 1'b1, '0, '0);
		// both marks, count over eight, all-ones seed and length
		queue_word('1, 4'd15, 1'b1, 1'b1, '1, '1);
		// exactly one group, then one group plus a tail word
		queue_message({$urandom, $urandom}, 32, 32, 1'b1, 1'b1);
		queue_message({$urandom, $urandom}, 40, 40, 1'b1, 1'b1);
		// partial word inside the groups, empty last word
		queue_word({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, {$urandom, $urandom}, 32'd64);
		queue_word('1, 4'd3, 1'b0, 1'b0, '0, '0);
		queue_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b0, '0, '0);
		queue_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b1, '0, '0);
		// zero data with only the top length bit set
		queue_word('0, 4'd8, 1'b1, 1'b1, '0, 32'h8000_0000);
		// one byte in the tail
		queue_message({$urandom, $urandom}, 33, 33, 1'b1, 1'b1);
		queue_random(WordsPerPhase - 23);
		wait_drained();

		// further phases under different fold rotations
		for (int p = 0; p < 4; p++) begin
			write_fold(rot_a_list[p], rot_b_list[p]);
			calm_sender = (p == 1);
			calm_receiver = (p == 1);
			@(posedge clk);
			queue_random(WordsPerPhase);
			wait_drained();
		end

		hash_errors += expected_hashes.size();
		$display("covered %0d words and %0d hashes over %0d fold rotation settings",
			accepted_words, hashes_checked, fold_settings);
		$display("%0d hash errors", hash_errors);
		if (hash_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
